FILE: rtl/tch_pkg.sv
`timescale 1ns / 1ps

package tch_pkg;

  // one input item
  typedef struct packed {
    logic        kind;
    logic [63:0] key;
    logic [15:0] ham_add;
    logic [15:0] spam_add;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] entry_key_out;
    logic [31:0] ham_total;
    logic [31:0] spam_total;
    logic        last;
  } out_item_t;

  // result status codes
  localparam logic [2:0] ST_NEW     = 3'd0;
  localparam logic [2:0] ST_MERGED  = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_DRAINED = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;

  // item kinds
  localparam logic KIND_ACC   = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // datapath commands issued by the controller
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_LATCH,
    OP_HRD,
    OP_HCUR,
    OP_WRD,
    OP_MERGE,
    OP_STEP,
    OP_FULL,
    OP_NEW,
    OP_LINK,
    OP_EMPTY,
    OP_DHRD,
    OP_DSKIP,
    OP_DENT,
    OP_DTAKE,
    OP_PUSH
  } op_e;

  // datapath status seen by the controller
  typedef struct packed {
    logic kind;
    logic rem_done;
    logic clr_last;
    logic cur_null;
    logic key_hit;
    logic pool_full;
    logic prev_null;
    logic live_zero;
    logic head_null;
    logic qualify;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/token_count_hash_table_top.sv
`timescale 1ns / 1ps
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_stall_o   | in_item_t
// out     | output    | out_valid_o/out_stall_i | out_item_t
// cfg     | input     | cfg_we_i             | cfg_wdata_i (drain threshold)
//
// accumulate: walks the chain of the key's bucket; hashing uses a remainder unit
//   when BUCKETS is not a power of two (four key bits a cycle)
// drain: removes entries bucket by bucket until one qualifies or none is left
// after reset a clearing pass over the bucket heads runs with in_stall_o high;
//   one item is worked at a time through the single-port stores
// a result waits in the output register; out_stall_i holds the next result back

module token_count_hash_table_top
  import tch_pkg::*;
#(
  parameter int BUCKETS  = 8192,
  parameter int CAPACITY = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  op_e  cmd;
  sts_t sts;

  tch_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .sts_i (sts),
    .cmd_o (cmd)
  );

  tch_dp #(
    .BUCKETS  (BUCKETS),
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i (cmd),
    .sts_o (sts),
    .in_item_i,
    .cfg_we_i,
    .cfg_wdata_i,
    .out_stall_i,
    .out_valid_o,
    .out_item_o
  );

endmodule

FILE: rtl/tch_rem.sv
`timescale 1ns / 1ps

module tch_rem #(
  parameter int BUCKETS = 8192
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [63:0]                key_i,
  output logic                       done_o,
  output logic [$clog2(BUCKETS)-1:0] bucket_o
);

  localparam int BW = $clog2(BUCKETS);
  localparam int WW = BW + 4;
  localparam bit IsPow2 = (BUCKETS & (BUCKETS - 1)) == 0;

  logic [BW-1:0] r_q, r_d;
  logic          busy_q, busy_d;
  logic [63:0]   sh_q, sh_d;
  logic [3:0]    cnt_q, cnt_d;
  logic [WW-1:0] wide, sub;

  // four key bits per cycle, largest fitting multiple of the bucket count taken off
  always_comb begin
    wide   = {r_q, sh_q[63:60]};
    sub    = '0;
    for (int k = 1; k < 16; k++) begin
      if (wide >= WW'(k * BUCKETS)) sub = WW'(k * BUCKETS);
    end
    r_d    = r_q;
    busy_d = busy_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      if (IsPow2) begin
        r_d = key_i[BW-1:0];
      end else begin
        r_d    = '0;
        busy_d = 1'b1;
        sh_d   = key_i;
        cnt_d  = '0;
      end
    end else if (busy_q) begin
      r_d   = BW'(wide - sub);
      sh_d  = {sh_q[59:0], 4'd0};
      cnt_d = cnt_q + 4'd1;
      if (cnt_q == 4'd15) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q  <= r_d;
    sh_q <= sh_d;
  end

  assign done_o   = !busy_q;
  assign bucket_o = r_q;

endmodule

FILE: rtl/tch_ctrl.sv
`timescale 1ns / 1ps

module tch_ctrl
  import tch_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  sts_t sts_i,
  output op_e  cmd_o
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DISP = 4'd2;
  localparam logic [3:0] S_HASH = 4'd3;
  localparam logic [3:0] S_HRD  = 4'd4;
  localparam logic [3:0] S_HCUR = 4'd5;
  localparam logic [3:0] S_WALK = 4'd6;
  localparam logic [3:0] S_CMP  = 4'd7;
  localparam logic [3:0] S_MISS = 4'd8;
  localparam logic [3:0] S_LINK = 4'd9;
  localparam logic [3:0] S_DCHK = 4'd10;
  localparam logic [3:0] S_DHD  = 4'd11;
  localparam logic [3:0] S_DEV  = 4'd12;
  localparam logic [3:0] S_DONE = 4'd13;

  logic [3:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  // next state and command
  always_comb begin
    state_d = state_q;
    cmd_o   = OP_NONE;
    unique case (state_q)
      S_CLR: begin
        cmd_o = OP_CLR;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = OP_LATCH;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        state_d = (sts_i.kind == KIND_ACC) ? S_HASH : S_DCHK;
      end
      S_HASH: begin
        if (sts_i.rem_done) state_d = S_HRD;
      end
      S_HRD: begin
        cmd_o   = OP_HRD;
        state_d = S_HCUR;
      end
      S_HCUR: begin
        cmd_o   = OP_HCUR;
        state_d = S_WALK;
      end
      S_WALK: begin
        if (sts_i.cur_null) begin
          state_d = S_MISS;
        end else begin
          cmd_o   = OP_WRD;
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        if (sts_i.key_hit) begin
          cmd_o   = OP_MERGE;
          state_d = S_DONE;
        end else begin
          cmd_o   = OP_STEP;
          state_d = S_WALK;
        end
      end
      S_MISS: begin
        if (sts_i.pool_full) begin
          cmd_o   = OP_FULL;
          state_d = S_DONE;
        end else begin
          cmd_o   = OP_NEW;
          state_d = sts_i.prev_null ? S_DONE : S_LINK;
        end
      end
      S_LINK: begin
        cmd_o   = OP_LINK;
        state_d = S_DONE;
      end
      S_DCHK: begin
        if (sts_i.live_zero) begin
          cmd_o   = OP_EMPTY;
          state_d = S_DONE;
        end else begin
          cmd_o   = OP_DHRD;
          state_d = S_DHD;
        end
      end
      S_DHD: begin
        if (sts_i.head_null) begin
          cmd_o   = OP_DSKIP;
          state_d = S_DCHK;
        end else begin
          cmd_o   = OP_DENT;
          state_d = S_DEV;
        end
      end
      S_DEV: begin
        cmd_o   = OP_DTAKE;
        state_d = sts_i.qualify ? S_DONE : S_DCHK;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o   = OP_PUSH;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/tch_dp.sv
`timescale 1ns / 1ps

module tch_dp
  import tch_pkg::*;
#(
  parameter int BUCKETS  = 8192,
  parameter int CAPACITY = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  op_e         cmd_i,
  output sts_t        sts_o,
  input  in_item_t    in_item_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        out_stall_i,
  output logic        out_valid_o,
  output out_item_t   out_item_o
);

  localparam int BW = $clog2(BUCKETS);
  localparam int PW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  // stores
  logic [PW-1:0] head_mem [BUCKETS];
  logic [63:0]   key_mem  [CAPACITY];
  logic [31:0]   ham_mem  [CAPACITY];
  logic [31:0]   spam_mem [CAPACITY];
  logic [PW-1:0] next_mem [CAPACITY];

  in_item_t      item_q;
  logic [31:0]   min_q;
  logic [BW-1:0] clr_q, db_q;
  logic [PW-1:0] pool_q, live_q, cur_q, prev_q;
  logic [PW-1:0] head_rd_q, next_rd_q;
  logic [63:0]   key_rd_q;
  logic [31:0]   ham_rd_q, spam_rd_q;
  out_item_t     res_q, out_q;
  logic          out_valid_q;

  logic          rem_start, rem_done;
  logic [BW-1:0] bucket;

  tch_rem #(.BUCKETS(BUCKETS)) u_rem (
    .clk_i,
    .rst_ni,
    .start_i  (rem_start),
    .key_i    (in_item_i.key),
    .done_o   (rem_done),
    .bucket_o (bucket)
  );

  assign rem_start = (cmd_i == OP_LATCH) && (in_item_i.kind == KIND_ACC);

  // saturating merge sums and drain threshold
  logic [32:0] ham_sum, spam_sum, tot_sum;
  logic [31:0] ham_sat, spam_sat;
  always_comb begin
    ham_sum  = {1'b0, ham_rd_q} + {17'd0, item_q.ham_add};
    spam_sum = {1'b0, spam_rd_q} + {17'd0, item_q.spam_add};
    ham_sat  = ham_sum[32] ? 32'hFFFF_FFFF : ham_sum[31:0];
    spam_sat = spam_sum[32] ? 32'hFFFF_FFFF : spam_sum[31:0];
    tot_sum  = {1'b0, ham_rd_q} + {1'b0, spam_rd_q};
  end

  logic [PW-1:0] cur_m1, prev_m1, head_m1;
  assign cur_m1  = cur_q - PW'(1);
  assign prev_m1 = prev_q - PW'(1);
  assign head_m1 = head_rd_q - PW'(1);

  // head store ports
  logic          head_we;
  logic [BW-1:0] head_waddr, head_raddr;
  logic [PW-1:0] head_wdata;
  always_comb begin
    head_we    = 1'b0;
    head_waddr = db_q;
    head_wdata = '0;
    head_raddr = (cmd_i == OP_HRD) ? bucket : db_q;
    case (cmd_i)
      OP_CLR: begin
        head_we    = 1'b1;
        head_waddr = clr_q;
      end
      OP_NEW: begin
        head_we    = prev_q == '0;
        head_waddr = bucket;
        head_wdata = pool_q + PW'(1);
      end
      OP_DTAKE: begin
        head_we    = 1'b1;
        head_wdata = next_rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (head_we) head_mem[head_waddr] <= head_wdata;
    if (cmd_i == OP_HRD || cmd_i == OP_DHRD) head_rd_q <= head_mem[head_raddr];
  end

  // entry store ports
  logic [IW-1:0] ent_addr;
  logic          ent_rd;
  always_comb begin
    case (cmd_i)
      OP_DENT: ent_addr = head_m1[IW-1:0];
      OP_NEW:  ent_addr = pool_q[IW-1:0];
      OP_LINK: ent_addr = prev_m1[IW-1:0];
      default: ent_addr = cur_m1[IW-1:0];
    endcase
    ent_rd = (cmd_i == OP_WRD) || (cmd_i == OP_DENT);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == OP_NEW) key_mem[ent_addr] <= item_q.key;
    if (ent_rd) key_rd_q <= key_mem[ent_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == OP_NEW) ham_mem[ent_addr] <= {16'd0, item_q.ham_add};
    else if (cmd_i == OP_MERGE) ham_mem[ent_addr] <= ham_sat;
    if (ent_rd) ham_rd_q <= ham_mem[ent_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == OP_NEW) spam_mem[ent_addr] <= {16'd0, item_q.spam_add};
    else if (cmd_i == OP_MERGE) spam_mem[ent_addr] <= spam_sat;
    if (ent_rd) spam_rd_q <= spam_mem[ent_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == OP_NEW) next_mem[ent_addr] <= '0;
    else if (cmd_i == OP_LINK) next_mem[ent_addr] <= pool_q;
    if (ent_rd) next_rd_q <= next_mem[ent_addr];
  end

  // control registers: pool fill, live count, drain position, clear sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      db_q        <= '0;
      pool_q      <= '0;
      live_q      <= '0;
      min_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) min_q <= cfg_wdata_i;
      if (cmd_i == OP_PUSH) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      case (cmd_i)
        OP_CLR: clr_q <= clr_q + BW'(1);
        OP_NEW: begin
          pool_q <= pool_q + PW'(1);
          live_q <= live_q + PW'(1);
        end
        OP_EMPTY: begin
          pool_q <= '0;
          db_q   <= '0;
        end
        OP_DSKIP: db_q <= (db_q == BW'(BUCKETS - 1)) ? '0 : db_q + BW'(1);
        OP_DTAKE: begin
          live_q <= live_q - PW'(1);
          if (sts_o.qualify && live_q == PW'(1)) begin
            pool_q <= '0;
            db_q   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // item, walk pointers and result
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      OP_LATCH: item_q <= in_item_i;
      OP_HCUR: begin
        cur_q  <= head_rd_q;
        prev_q <= '0;
      end
      OP_STEP: begin
        prev_q <= cur_q;
        cur_q  <= next_rd_q;
      end
      OP_MERGE: res_q <= '{status: ST_MERGED, entry_key_out: '0, ham_total: ham_sat,
                           spam_total: spam_sat, last: 1'b0};
      OP_FULL:  res_q <= '{status: ST_FULL, entry_key_out: '0, ham_total: '0,
                           spam_total: '0, last: 1'b0};
      OP_NEW:   res_q <= '{status: ST_NEW, entry_key_out: '0,
                           ham_total: {16'd0, item_q.ham_add},
                           spam_total: {16'd0, item_q.spam_add}, last: 1'b0};
      OP_EMPTY: res_q <= '{status: ST_EMPTY, entry_key_out: '0, ham_total: '0,
                           spam_total: '0, last: 1'b0};
      OP_DTAKE: res_q <= '{status: ST_DRAINED, entry_key_out: key_rd_q,
                           ham_total: ham_rd_q, spam_total: spam_rd_q,
                           last: live_q == PW'(1)};
      OP_PUSH:  out_q <= res_q;
      default: ;
    endcase
  end

  // status toward the controller
  always_comb begin
    sts_o.kind      = item_q.kind;
    sts_o.rem_done  = rem_done;
    sts_o.clr_last  = clr_q == BW'(BUCKETS - 1);
    sts_o.cur_null  = cur_q == '0;
    sts_o.key_hit   = key_rd_q == item_q.key;
    sts_o.pool_full = pool_q >= PW'(CAPACITY);
    sts_o.prev_null = prev_q == '0;
    sts_o.live_zero = live_q == '0;
    sts_o.head_null = head_rd_q == '0;
    sts_o.qualify   = tot_sum > {1'b0, min_q};
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: rtl/tch_chk.sv
`timescale 1ns / 1ps

module tch_chk
  import tch_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed");

  // one item at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item taken while busy");

  // key and last only on a drained entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != ST_DRAINED |->
      out_item_o.entry_key_out == '0 && !out_item_o.last)
    else $error("key or last on non-drain result");

  // empty and full results carry no counts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_item_o.status == ST_EMPTY || out_item_o.status == ST_FULL) |->
      out_item_o.ham_total == '0 && out_item_o.spam_total == '0)
    else $error("counts on empty or full result");

endmodule

bind token_count_hash_table_top tch_chk u_chk (.*);

FILE: tb/token_count_hash_table_top_tb.sv
`timescale 1ns / 1ps

module token_count_hash_table_top_tb;
  import tch_pkg::*;

  localparam int NBKT = 8192;
  localparam int NCAP = 4096;
  localparam longint CYCLE_LIMIT = 20000000;

  // expected-result tracker with its own copy of the table
  class count_table_board;
    logic [31:0] min_total;
    logic [12:0] head[NBKT];
    logic [63:0] ent_key[NCAP];
    logic [31:0] ent_ham[NCAP];
    logic [31:0] ent_spam[NCAP];
    logic [12:0] ent_next[NCAP];
    int unsigned used;
    int unsigned scan_bkt;
    int unsigned live;
    out_item_t   pending_q[$];
    int          errors;

    function new();
      min_total = '0;
      foreach (head[i]) head[i] = '0;
      used = 0;
      scan_bkt = 0;
      live = 0;
      errors = 0;
    endfunction

    function logic [31:0] sat_add(logic [31:0] a, logic [15:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {17'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // work out the result that an accepted item will cause
    function void note_item(in_item_t it);
      out_item_t   r;
      int unsigned cur, prev, i, n, b;
      bit          hit, found;
      logic [32:0] sum;
      r = '0;
      if (it.kind == KIND_ACC) begin
        b = it.key[12:0];
        cur = head[b];
        prev = 0;
        hit = 0;
        i = 0;
        while (cur != 0 && !hit) begin
          i = cur - 1;
          if (ent_key[i] == it.key) hit = 1;
          else begin
            prev = cur;
            cur = ent_next[i];
          end
        end
        if (hit) begin
          ent_ham[i] = sat_add(ent_ham[i], it.ham_add);
          ent_spam[i] = sat_add(ent_spam[i], it.spam_add);
          r.status = ST_MERGED;
          r.ham_total = ent_ham[i];
          r.spam_total = ent_spam[i];
        end else if (used >= NCAP) begin
          r.status = ST_FULL;
        end else begin
          n = used;
          used++;
          ent_key[n] = it.key;
          ent_ham[n] = {16'b0, it.ham_add};
          ent_spam[n] = {16'b0, it.spam_add};
          ent_next[n] = '0;
          if (prev != 0) ent_next[prev - 1] = 13'(n + 1);
          else head[b] = 13'(n + 1);
          live++;
          r.status = ST_NEW;
          r.ham_total = {16'b0, it.ham_add};
          r.spam_total = {16'b0, it.spam_add};
        end
      end else begin
        found = 0;
        while (live > 0 && !found) begin
          cur = head[scan_bkt];
          if (cur == 0) begin
            scan_bkt = (scan_bkt + 1) % NBKT;
          end else begin
            i = cur - 1;
            head[scan_bkt] = ent_next[i];
            live--;
            sum = {1'b0, ent_ham[i]} + {1'b0, ent_spam[i]};
            if (sum > {1'b0, min_total}) begin
              found = 1;
              r.status = ST_DRAINED;
              r.entry_key_out = ent_key[i];
              r.ham_total = ent_ham[i];
              r.spam_total = ent_spam[i];
              r.last = (live == 0);
            end
          end
        end
        if (live == 0) begin
          used = 0;
          scan_bkt = 0;
        end
        if (!found) r.status = ST_EMPTY;
      end
      pending_q.push_back(r);
    endfunction

    // compare one result with the oldest expectation
    function void check_result(out_item_t got);
      out_item_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      e = pending_q.pop_front();
      if (got.status !== e.status) begin
        $display("%0t: status exp %0d got %0d", $time, e.status, got.status);
        errors++;
      end
      if (got.entry_key_out !== e.entry_key_out) begin
        $display("%0t: key exp %h got %h", $time, e.entry_key_out, got.entry_key_out);
        errors++;
      end
      if (got.ham_total !== e.ham_total) begin
        $display("%0t: ham exp %h got %h", $time, e.ham_total, got.ham_total);
        errors++;
      end
      if (got.spam_total !== e.spam_total) begin
        $display("%0t: spam exp %h got %h", $time, e.spam_total, got.spam_total);
        errors++;
      end
      if (got.last !== e.last) begin
        $display("%0t: last exp %0d got %0d", $time, e.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_item_t   out_item_o;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  count_table_board board = new();
  int     idle_pct = 0;
  int     stall_pct = 0;
  int     hold_left = 0;
  longint cycles = 0;
  logic [63:0] key_pool[$];

  token_count_hash_table_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // receiver stalls, with a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) board.check_result(out_item_o);
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // offer one item and hold it until accepted
  task automatic send_item(in_item_t it);
    in_valid_i <= 1'b1;
    in_item_i <= it;
    forever begin
      @(posedge clk_i);
      if (!in_stall_o) break;
    end
    board.note_item(it);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic send_acc(logic [63:0] k, logic [15:0] h, logic [15:0] s);
    in_item_t it;
    it.kind = KIND_ACC;
    it.key = k;
    it.ham_add = h;
    it.spam_add = s;
    send_item(it);
  endtask

  task automatic send_drain();
    in_item_t it;
    it.kind = KIND_DRAIN;
    it.key = {$urandom, $urandom};
    it.ham_add = 16'($urandom);
    it.spam_add = 16'($urandom);
    send_item(it);
  endtask

  // drain until the table is empty, then once more
  task automatic drain_all();
    while (board.live > 0) send_drain();
    send_drain();
  endtask

  // stop offering and wait for every expected result
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_threshold(logic [31:0] v);
    wait_quiet();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    board.min_total = v;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // keys mostly land in a few low buckets to keep drain scans short
  function automatic logic [63:0] pick_key();
    logic [63:0] k;
    if (key_pool.size() > 0 && $urandom_range(0, 1)) begin
      return key_pool[$urandom_range(0, key_pool.size() - 1)];
    end
    k = {$urandom, $urandom};
    if ($urandom_range(0, 99) != 0) k[12:0] = 13'($urandom_range(0, 7));
    key_pool.push_back(k);
    if (key_pool.size() > 40) void'(key_pool.pop_front());
    return k;
  endfunction

  function automatic logic [15:0] pick_count();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // random sessions: short mixes of accumulates and drains, or a fill with accumulates then a drain down
  task automatic random_phase(int n_items);
    int done;
    int k;
    done = 0;
    while (done < n_items) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 12)) begin
          if ($urandom_range(0, 1)) send_drain();
          else send_acc(pick_key(), pick_count(), pick_count());
          done++;
        end
      end else begin
        k = $urandom_range(3, 30);
        repeat (k) send_acc(pick_key(), pick_count(), pick_count());
        done += k + board.live + 1;
        drain_all();
      end
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_threshold(32'd0);

    // directed: empty drain, extremes, chaining, skip of zero totals
    send_drain();
    send_acc(64'h0, 16'h0, 16'h0);
    send_acc(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_acc(64'd8192, 16'h0, 16'h0);
    send_acc(64'd16384, 16'h1, 16'h0);
    send_acc(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF);
    send_acc(64'd16384, 16'h0, 16'h1);
    send_drain();
    send_acc(64'd1, 16'h5, 16'h5);
    drain_all();
    send_acc(64'hAAAA_5555_AAAA_5555, 16'hAAAA, 16'h5555);
    send_acc(64'h5555_AAAA_5555_AAAA, 16'h5555, 16'hAAAA);
    send_drain();
    send_drain();
    send_drain();

    // repeated merges on one key, then threshold at its top
    set_threshold(32'd0);
    repeat (40) send_acc(64'h1234_5678_9ABC_0003, 16'hFFFF, 16'hFFFF);
    send_acc(64'h0000_0000_0000_0004, 16'h0001, 16'h0000);
    set_threshold(32'hFFFF_FFFF);
    drain_all();

    // random phases with different idling
    set_threshold(32'd0);
    idle_pct = 0;
    stall_pct = 0;
    random_phase(400);
    set_threshold($urandom_range(1, 150000));
    idle_pct = 61;
    stall_pct = 0;
    random_phase(400);
    set_threshold(32'd1000);
    idle_pct = 0;
    stall_pct = 61;
    hold_left = 400;
    random_phase(400);
    set_threshold(32'd0);
    idle_pct = 17;
    stall_pct = 17;
    random_phase(400);

    wait_quiet();
    repeat (50) @(posedge clk_i);
    if (board.errors == 0 && board.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
